@@ hdl/npcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcm_pkg: shared definitions for the nearest palette color match core
// Defaults for the module parameters, request codes and sequencer states.
// ----------------------------------------------------------------------------
package npcm_pkg;

  // default palette depth and bits per color component
  localparam int PaletteEntriesDef = 256;
  localparam int ComponentBitsDef  = 6;

  // running best distance at the start of every search
  localparam int StartDist = 255;

  // first palette entry visited by a search
  localparam int FirstScanIdx = 1;

  // request codes carried on the mode field
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_MATCH = 2'd1;
  localparam logic [1:0] MODE_BLEND = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // search sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLEND,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_e;

endpackage

@@ hdl/nearest_palette_color_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core: nearest palette color by L1 distance
// Palette store with write, match and blend-then-match requests.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one request: mode_i,
//   entry_index_i and a red/green/blue color. A write request stores the color
//   into the palette in the transfer cycle and yields no result; the block is
//   ready again on the next cycle. A match request searches entries 1 through
//   PALETTE_ENTRIES-2 for the least sum of absolute channel differences; the
//   first minimum wins and index 1 stands when no distance is below 255. A
//   blend request first averages the chosen entry with the given tint, then
//   searches the same way. Mode 3 is taken and dropped.
//   A search reads one palette entry per cycle through the single read port of
//   the palette memory; the block is not ready meanwhile. The result waits in
//   an output register (out_valid_o / out_ready_i); a new request is taken
//   while a result waits, but its result is held back until the old one is
//   transferred.
//   Reset clears the control state and all per-entry valid bits, so every
//   palette entry reads as black right away; there is no clearing pass.
// ----------------------------------------------------------------------------
module nearest_palette_color_match_core #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PaletteEntriesDef,
  parameter int COMPONENT_BITS  = npcm_pkg::ComponentBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic [7:0]                entry_index_i,
  input  logic [COMPONENT_BITS-1:0] red_i,
  input  logic [COMPONENT_BITS-1:0] green_i,
  input  logic [COMPONENT_BITS-1:0] blue_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                nearest_index_o
);

  localparam int CB     = COMPONENT_BITS;
  localparam int IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int ENT_W  = 3 * CB;
  // sum of three channel differences
  localparam int DIST_W = CB + 2;
  // best distance must also hold the start value
  localparam int BEST_W = (DIST_W > 8) ? DIST_W : 8;
  localparam logic [IDX_W-1:0]  FIRST_IDX  = IDX_W'(npcm_pkg::FirstScanIdx);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(PALETTE_ENTRIES - 2);
  localparam logic [BEST_W-1:0] START_BEST = BEST_W'(npcm_pkg::StartDist);
  localparam logic [8:0]        ENTRIES_9  = 9'(PALETTE_ENTRIES);

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a,
                                             input logic [CB-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  npcm_pkg::state_e state_q, state_d;

  logic [ENT_W-1:0]  palette_mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] entry_vld_q;

  logic [ENT_W-1:0]  rd_data_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_addr;

  logic [CB-1:0]     qr_q, qg_q, qb_q, qr_d, qg_d, qb_d;
  logic              in_range_q, in_range_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic              cmp_vld_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic [BEST_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  logic in_xfer;
  logic in_range;
  logic wr_en;
  logic out_free;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign in_range = {1'b0, entry_index_i} < ENTRIES_9;
  assign wr_en    = in_xfer && (mode_i == npcm_pkg::MODE_WRITE) && in_range;
  assign out_free = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      npcm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          unique case (mode_i)
            npcm_pkg::MODE_MATCH: state_d = npcm_pkg::ST_SCAN;
            npcm_pkg::MODE_BLEND: state_d = npcm_pkg::ST_BLEND;
            default:              state_d = npcm_pkg::ST_IDLE;
          endcase
        end
      end
      npcm_pkg::ST_BLEND: state_d = npcm_pkg::ST_SCAN;
      npcm_pkg::ST_SCAN: begin
        if (scan_q == LAST_IDX) begin
          state_d = npcm_pkg::ST_FLUSH;
        end
      end
      npcm_pkg::ST_FLUSH: state_d = npcm_pkg::ST_DONE;
      npcm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = npcm_pkg::ST_IDLE;
        end
      end
      default: state_d = npcm_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: handshake and read address
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    rd_addr    = entry_index_i[IDX_W-1:0];
    unique case (state_q)
      npcm_pkg::ST_IDLE: in_ready_o = 1'b1;
      npcm_pkg::ST_SCAN: rd_addr    = scan_q;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared distance unit: three absolute differences, two adds, one compare
  // --------------------------------------------------------------------------
  logic [CB-1:0]     ent_r, ent_g, ent_b;
  logic [DIST_W-1:0] l1_dist;
  logic              better;

  // never written entries read as black
  assign ent_r   = rd_vld_q ? rd_data_q[ENT_W-1 -: CB] : '0;
  assign ent_g   = rd_vld_q ? rd_data_q[2*CB-1 -: CB] : '0;
  assign ent_b   = rd_vld_q ? rd_data_q[CB-1:0] : '0;
  assign l1_dist = DIST_W'(abs_diff(ent_r, qr_q)) + DIST_W'(abs_diff(ent_g, qg_q))
                 + DIST_W'(abs_diff(ent_b, qb_q));
  assign better  = cmp_vld_q && (BEST_W'(l1_dist) < best_q);

  // blend inputs: a missing or never written entry reads as black
  logic [CB-1:0] bl_r, bl_g, bl_b;
  logic          bl_use;
  logic [CB:0]   sum_r, sum_g, sum_b;

  assign bl_use = in_range_q && rd_vld_q;
  assign bl_r   = bl_use ? ent_r : '0;
  assign bl_g   = bl_use ? ent_g : '0;
  assign bl_b   = bl_use ? ent_b : '0;
  assign sum_r  = {1'b0, bl_r} + {1'b0, qr_q};
  assign sum_g  = {1'b0, bl_g} + {1'b0, qg_q};
  assign sum_b  = {1'b0, bl_b} + {1'b0, qb_q};

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    qr_d        = qr_q;
    qg_d        = qg_q;
    qb_d        = qb_q;
    in_range_d  = in_range_q;
    scan_d      = scan_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;

    // capture query color, or tint for a blend
    if (in_xfer) begin
      qr_d       = red_i;
      qg_d       = green_i;
      qb_d       = blue_i;
      in_range_d = in_range;
    end

    if (state_q == npcm_pkg::ST_BLEND) begin
      qr_d = sum_r[CB:1];
      qg_d = sum_g[CB:1];
      qb_d = sum_b[CB:1];
    end

    // reset the search on the way into the scan
    if (state_d == npcm_pkg::ST_SCAN && state_q != npcm_pkg::ST_SCAN) begin
      scan_d     = FIRST_IDX;
      best_d     = START_BEST;
      best_idx_d = FIRST_IDX;
    end else begin
      if (state_q == npcm_pkg::ST_SCAN) begin
        scan_d = scan_q + IDX_W'(1);
      end
      if (better) begin
        best_d     = BEST_W'(l1_dist);
        best_idx_d = cmp_idx_q;
      end
    end

    // hand over to the output register; drop it once transferred
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == npcm_pkg::ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_idx_d   = best_idx_q;
    end
  end

  // --------------------------------------------------------------------------
  // Palette memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      palette_mem[entry_index_i[IDX_W-1:0]] <= {red_i, green_i, blue_i};
    end
    rd_data_q <= palette_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Control and datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= npcm_pkg::ST_IDLE;
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (wr_en) begin
        entry_vld_q[entry_index_i[IDX_W-1:0]] <= 1'b1;
      end
      rd_vld_q    <= entry_vld_q[rd_addr];
      cmp_vld_q   <= (state_q == npcm_pkg::ST_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qr_q       <= qr_d;
    qg_q       <= qg_d;
    qb_q       <= qb_d;
    in_range_q <= in_range_d;
    scan_q     <= scan_d;
    cmp_idx_q  <= scan_q;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_idx_q  <= out_idx_d;
  end

  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = 8'(out_idx_q);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a compared entry lies inside the searched range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (cmp_idx_q >= FIRST_IDX) && (cmp_idx_q <= LAST_IDX))
    else $error("compare index outside search range");

  // a new result appears only out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == npcm_pkg::ST_DONE))
    else $error("result raised outside done state");

  // every scan starts at the first searched entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == npcm_pkg::ST_SCAN && $past(state_q) != npcm_pkg::ST_SCAN)
      |-> (scan_q == FIRST_IDX))
    else $error("scan did not start at first entry");

  // the best distance is not above its start value once the scan has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == npcm_pkg::ST_FLUSH || state_q == npcm_pkg::ST_DONE)
      |-> (best_q <= START_BEST))
    else $error("best distance above start value");

endmodule
